// ----- sv/u2a_pkg.sv -----
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and the letter table of the UTF-8 to ASCII
// transliterator.
// ----------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

    // Configuration register map
    localparam int unsigned RegCount   = 1;
    localparam int unsigned AddrW      = 3;
    localparam logic [0:0]  RegMaxOut  = 1'd0;
    localparam logic [15:0] MaxOutRst  = 16'd64;

    // Characters
    localparam logic [6:0]  CharQuest  = 7'h3F;
    localparam logic [6:0]  CharNul    = 7'h00;
    localparam logic [7:0]  ByteSpace  = 8'h20;
    localparam logic [7:0]  ByteDel    = 8'h7F;

    // Lead and continuation prefixes
    localparam logic [1:0]  PfxCont    = 2'b10;
    localparam logic [2:0]  PfxLead2   = 3'b110;
    localparam logic [3:0]  PfxLead3   = 4'b1110;
    localparam logic [4:0]  PfxLead4   = 5'b11110;

    // One result beat
    typedef struct packed {
        logic        vld;
        logic [6:0]  ch;
        logic        eos;
        logic [15:0] cnt;
    } t_res;

    // Up to two results caused by one input byte, in order
    typedef struct packed {
        t_res r1;
        t_res r0;
    } t_pair;

    // Map a decoded code point to a plain letter, '?' otherwise
    function automatic logic [6:0] translit(input logic [20:0] cp);
        logic [6:0] ch;
        case (cp)
            21'h000103, 21'h0000E2: ch = 7'h61;  // a
            21'h000102, 21'h0000C2: ch = 7'h41;  // A
            21'h0000EE:             ch = 7'h69;  // i
            21'h0000CE:             ch = 7'h49;  // I
            21'h000219, 21'h00015F: ch = 7'h73;  // s
            21'h000218, 21'h00015E: ch = 7'h53;  // S
            21'h00021B, 21'h000163: ch = 7'h74;  // t
            21'h00021A, 21'h000162: ch = 7'h54;  // T
            default:                ch = CharQuest;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/u2a_if.sv -----
// ----------------------------------------------------------------------------
// u2a_if
// Valid/ready channels of the transliterator: input bytes and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface u2a_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u2a_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  out_char;
    logic        end_of_string;
    logic [15:0] char_count;

    modport source (output valid, output out_char, output end_of_string,
                    output char_count, input ready);
    modport sink   (input valid, input out_char, input end_of_string,
                    input char_count, output ready);
endinterface

`default_nettype wire

// ----- sv/u2a_dec.sv -----
// ----------------------------------------------------------------------------
// u2a_dec
// Decoder state and the single-pass step logic: one byte in, up to two
// ordered results out, state updated on each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_dec (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  wire [7:0]           i_data,
    input  wire [15:0]          i_max_out,
    output u2a_pkg::t_pair      o_pair
);

    logic [1:0]  r_bytes_left, n_bytes_left;
    logic [20:0] r_code,       n_code;
    logic [15:0] r_emitted,    n_emitted;
    logic        r_full,       n_full;

    u2a_pkg::t_res res0, res1, lres;
    logic [20:0]   acc;
    logic [15:0]   cur;
    logic          lead;

    // Step the decoder for the byte at the input
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_code       = r_code;
        n_emitted    = r_emitted;
        n_full       = r_full;
        res0         = '0;
        res1         = '0;
        lres         = '0;
        acc          = {r_code[14:0], i_data[5:0]};
        cur          = r_emitted;
        lead         = 1'b1;

        // Continue or break an open sequence
        if (r_bytes_left != 2'd0) begin
            if (i_data[7:6] == u2a_pkg::PfxCont) begin
                lead         = 1'b0;
                n_code       = acc;
                n_bytes_left = r_bytes_left - 2'd1;
                if (r_bytes_left == 2'd1) begin
                    cur       = cur + 16'd1;
                    res0      = '{vld: 1'b1, ch: u2a_pkg::translit(acc), eos: 1'b0,
                                  cnt: cur};
                    n_code    = '0;
                    n_emitted = cur;
                end
            end else begin
                cur          = cur + 16'd1;
                res0         = '{vld: 1'b1, ch: u2a_pkg::CharQuest, eos: 1'b0, cnt: cur};
                n_bytes_left = 2'd0;
                n_code       = '0;
                n_emitted    = cur;
            end
        end

        // Handle the byte as a new lead
        if (lead) begin
            if (i_data == 8'd0) begin
                lres         = '{vld: 1'b1, ch: u2a_pkg::CharNul, eos: 1'b1, cnt: cur};
                n_bytes_left = 2'd0;
                n_code       = '0;
                n_emitted    = '0;
                n_full       = 1'b0;
            end else if (r_full || ({1'b0, cur} + 17'd1 >= {1'b0, i_max_out})) begin
                n_full = 1'b1;
            end else if (!i_data[7]) begin
                if (i_data >= u2a_pkg::ByteSpace && i_data != u2a_pkg::ByteDel) begin
                    lres      = '{vld: 1'b1, ch: i_data[6:0], eos: 1'b0,
                                  cnt: cur + 16'd1};
                    n_emitted = cur + 16'd1;
                end
            end else if (i_data[7:5] == u2a_pkg::PfxLead2) begin
                n_code       = {16'd0, i_data[4:0]};
                n_bytes_left = 2'd1;
            end else if (i_data[7:4] == u2a_pkg::PfxLead3) begin
                n_code       = {17'd0, i_data[3:0]};
                n_bytes_left = 2'd2;
            end else if (i_data[7:3] == u2a_pkg::PfxLead4) begin
                n_code       = {18'd0, i_data[2:0]};
                n_bytes_left = 2'd3;
            end else begin
                lres      = '{vld: 1'b1, ch: u2a_pkg::CharQuest, eos: 1'b0,
                              cnt: cur + 16'd1};
                n_emitted = cur + 16'd1;
            end
        end

        // Pack results in order
        if (lres.vld) begin
            if (res0.vld) begin
                res1 = lres;
            end else begin
                res0 = lres;
            end
        end
    end

    assign o_pair = '{r1: res1, r0: res0};

    // Advance state on an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_code       <= '0;
            r_emitted    <= '0;
            r_full       <= 1'b0;
        end else if (i_fire) begin
            r_bytes_left <= n_bytes_left;
            r_code       <= n_code;
            r_emitted    <= n_emitted;
            r_full       <= n_full;
        end
    end

    // A second result always follows a first one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pair.r1.vld |-> o_pair.r0.vld)
        else $error("second result without first");

    // An end result is never followed by another in the same step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pair.r0.eos && o_pair.r0.vld |-> !o_pair.r1.vld)
        else $error("result after end of string");

    // The terminator leaves the decoder cleared
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_data == 8'd0 |=> r_bytes_left == 2'd0 && r_emitted == 16'd0 && !r_full)
        else $error("state not cleared after terminator");

endmodule

`default_nettype wire

// ----- sv/utf8_to_ascii_transliterator.sv -----
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator
// Byte-serial UTF-8 decoder that emits plain ASCII with a per-string count.
// ----------------------------------------------------------------------------
// Results are registered: a byte's results enter the result queue when it is accepted.
// Throughput: one byte per cycle while the result queue has room; a byte that
//   causes two results occupies the output for two beats; the two-entry queue sets the stall.
// Reset: synchronous active-low; clears decoder state and queue, max_out = 64.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ascii_transliterator (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    u2a_in_if.sink                             i_byte,
    u2a_out_if.source                          o_res,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [u2a_pkg::AddrW-1:0]           paddr,
    input  wire [31:0]                         pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [15:0]    r_max_out;
    logic           reg_sel;
    logic           fire;
    u2a_pkg::t_pair pair;

    u2a_pkg::t_pair r_q [2];
    logic           r_wp, r_rp, r_half;
    logic [1:0]     r_cnt;
    u2a_pkg::t_pair head;
    logic           push, pop, beat, last_beat;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[u2a_pkg::AddrW-1:2] == u2a_pkg::RegMaxOut);
    assign prdata  = reg_sel ? {16'd0, r_max_out} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out <= u2a_pkg::MaxOutRst;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_max_out <= pwdata[15:0];
        end
    end

    // Accept a byte while the queue has room
    assign i_byte.ready = (r_cnt != 2'd2);
    assign fire         = i_byte.valid && i_byte.ready;

    u2a_dec u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_data    (i_byte.in_byte),
        .i_max_out (r_max_out),
        .o_pair    (pair)
    );

    // Result queue, one entry per byte that produced results
    assign head      = r_q[r_rp];
    assign beat      = o_res.valid && o_res.ready;
    assign last_beat = !head.r1.vld || r_half;
    assign push      = fire && pair.r0.vld;
    assign pop       = beat && last_beat;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_half <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (beat) begin
                r_half <= !last_beat;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Drive the output beat
    assign o_res.valid         = (r_cnt != 2'd0);
    assign o_res.out_char      = r_half ? head.r1.ch  : head.r0.ch;
    assign o_res.end_of_string = r_half ? head.r1.eos : head.r0.eos;
    assign o_res.char_count    = r_half ? head.r1.cnt : head.r0.cnt;

    // Queue never overflows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue overflow");

    // No push into a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !push)
        else $error("push into full queue");

    // Second half is only selected for a two-result entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> o_res.valid && head.r1.vld)
        else $error("second half selected without second result");

endmodule

`default_nettype wire
